>>> hw/rtl/bpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpid_pkg;

    localparam int DATA_W    = 32;
    localparam int BOUND_W   = 31;
    localparam int DT_W      = 16;
    localparam int ERR_W     = 33;
    localparam int INT_W     = 48;
    localparam int NUM_W     = 49;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_BOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_BOUND    = 3'd4;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/bpid_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpid_in_if;
    import bpid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic        [DT_W-1:0]   time_step;

    modport source (output valid, output command, output setpoint, output measured,
                    output time_step, input ready);
    modport sink (input valid, input command, input setpoint, input measured,
                  input time_step, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bpid_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpid_out_if;
    import bpid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bounded_pid_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// i_in      in   valid / ready      command, setpoint, measured, time_step
// o_out     out  valid / ready      drive
// i_cfg_*   in   write enable only  index, data (gains, integral and drive bounds)
//
// an update item runs through the sequencer states, plus the 49-step divider when the
// derivative is formed; a clear item gives no result
// one shared 34x17 multiplier serves the integral step and the three gain products
// reset is synchronous and clears gains, bounds, integral, history and the sequencer
// a waiting result is held in the output register while the next item is taken

module bounded_pid_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpid_pkg::DATA_W-1:0]       i_cfg_data,
    bpid_in_if.sink                           i_in,
    bpid_out_if.source                        o_out
);
    import bpid_pkg::*;

    localparam int ACC_W = 80;
    localparam int SUM_W = 50;
    localparam int PRD_W = 51;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INC_MUL = 4'd1;
    localparam logic [3:0] ST_INC_ADD = 4'd2;
    localparam logic [3:0] ST_ICLAMP  = 4'd3;
    localparam logic [3:0] ST_DIV     = 4'd4;
    localparam logic [3:0] ST_DSIGN   = 4'd5;
    localparam logic [3:0] ST_MUL     = 4'd6;
    localparam logic [3:0] ST_ACC     = 4'd7;
    localparam logic [3:0] ST_SAT     = 4'd8;
    localparam logic [3:0] ST_BOUND   = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    localparam logic [1:0] CHUNK_LO  = 2'd0;
    localparam logic [1:0] CHUNK_MID = 2'd1;
    localparam logic [1:0] CHUNK_HI  = 2'd2;

    localparam logic signed [INT_W-1:0]  MAX48 = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0]  MIN48 = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W-1:0]  r_gain_p;
    logic signed [DATA_W-1:0]  r_gain_i;
    logic signed [DATA_W-1:0]  r_gain_d;
    logic        [BOUND_W-1:0] r_ibound;
    logic        [BOUND_W-1:0] r_dbound;

    logic signed [INT_W-1:0]   r_integral;
    logic signed [ERR_W-1:0]   r_last_err;
    logic                      r_first;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic signed [ERR_W-1:0]   r_err;
    logic        [DT_W-1:0]    r_dt;
    logic                      r_diff_neg;
    logic signed [INT_W-1:0]   r_deriv;
    logic signed [PRD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   r_sum;
    logic [1:0]                r_term;
    logic [1:0]                r_chunk;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;

    logic                      in_accept;
    logic                      out_free;
    logic signed [ERR_W:0]     mul_a;
    logic signed [DT_W:0]      mul_b;
    logic signed [DATA_W-1:0]  gain_sel;
    logic signed [INT_W-1:0]   val_sel;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   acc_add;
    logic signed [INT_W:0]     isum;
    logic signed [INT_W-1:0]   isum_sat;
    logic signed [INT_W-1:0]   ib_pos;
    logic signed [INT_W-1:0]   ib_neg;
    logic signed [ERR_W:0]     diff;
    logic        [ERR_W:0]     diff_mag;
    logic                      div_start;
    logic                      div_done;
    logic        [NUM_W-1:0]   div_quo;
    logic signed [INT_W-1:0]   deriv_val;
    logic signed [INT_W-1:0]   term_val;
    logic signed [SUM_W-1:0]   db_pos;
    logic signed [SUM_W-1:0]   db_neg;
    logic signed [DATA_W-1:0]  drive_sat;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;

    // shared multiplier operands
    always_comb begin
        unique case (r_term)
            TERM_P:  gain_sel = r_gain_p;
            TERM_I:  gain_sel = r_gain_i;
            default: gain_sel = r_gain_d;
        endcase
        unique case (r_term)
            TERM_P:  val_sel = {{(INT_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            TERM_I:  val_sel = r_integral;
            default: val_sel = r_deriv;
        endcase
        if (r_state == ST_INC_MUL) begin
            mul_a = {r_err[ERR_W-1], r_err};
            mul_b = {1'b0, r_dt};
        end else begin
            mul_a = {{(ERR_W+1-DATA_W){gain_sel[DATA_W-1]}}, gain_sel};
            unique case (r_chunk)
                CHUNK_LO:  mul_b = {1'b0, val_sel[15:0]};
                CHUNK_MID: mul_b = {1'b0, val_sel[31:16]};
                default:   mul_b = {val_sel[INT_W-1], val_sel[INT_W-1:32]};
            endcase
        end
    end

    assign prod_ext = {{(ACC_W-PRD_W){r_prod[PRD_W-1]}}, r_prod};
    always_comb begin
        unique case (r_chunk)
            CHUNK_LO:  acc_add = prod_ext;
            CHUNK_MID: acc_add = prod_ext <<< 16;
            default:   acc_add = prod_ext <<< 32;
        endcase
    end

    // integral step: floor(error * dt / 2^16), saturated to 48 bits
    assign isum = {r_integral[INT_W-1], r_integral}
                + {{(INT_W+1-(PRD_W-16)){r_prod[PRD_W-1]}}, r_prod[PRD_W-1:16]};
    assign isum_sat = (isum[INT_W] != isum[INT_W-1]) ? (isum[INT_W] ? MIN48 : MAX48)
                                                     : isum[INT_W-1:0];
    assign ib_pos = {{(INT_W-BOUND_W){1'b0}}, r_ibound};
    assign ib_neg = -ib_pos;

    assign diff     = {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
    assign diff_mag = diff[ERR_W] ? -diff : diff;
    assign div_start = (r_state == ST_ICLAMP) && (r_dt != '0) && !r_first;

    bpid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({diff_mag[ERR_W-1:0], 16'b0}),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        if (r_diff_neg) begin
            if (div_quo[NUM_W-1] || (div_quo[INT_W-1] && (|div_quo[INT_W-2:0]))) begin
                deriv_val = MIN48;
            end else begin
                deriv_val = -$signed(div_quo[INT_W-1:0]);
            end
        end else begin
            if (div_quo[NUM_W-1:INT_W-1] != '0) begin
                deriv_val = MAX48;
            end else begin
                deriv_val = $signed(div_quo[INT_W-1:0]);
            end
        end
    end

    // floor shift by 16, saturated to 48 bits
    assign term_val = (r_acc[ACC_W-1:63] == {(ACC_W-63){r_acc[63]}}) ? r_acc[63:16]
                    : (r_acc[ACC_W-1] ? MIN48 : MAX48);

    assign db_pos = {{(SUM_W-BOUND_W){1'b0}}, r_dbound};
    assign db_neg = -db_pos;
    assign drive_sat = (r_sum[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){r_sum[DATA_W-1]}})
                     ? r_sum[DATA_W-1:0] : (r_sum[SUM_W-1] ? MIN32 : MAX32);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in.command == CMD_UPDATE) n_state = ST_INC_MUL;
            end
            ST_INC_MUL: n_state = ST_INC_ADD;
            ST_INC_ADD: n_state = ST_ICLAMP;
            ST_ICLAMP:  n_state = div_start ? ST_DIV : ST_MUL;
            ST_DIV: begin
                if (div_done) n_state = ST_DSIGN;
            end
            ST_DSIGN:   n_state = ST_MUL;
            ST_MUL:     n_state = ST_ACC;
            ST_ACC:     n_state = (r_chunk == CHUNK_HI) ? ST_SAT : ST_MUL;
            ST_SAT:     n_state = (r_term == TERM_D) ? ST_BOUND : ST_MUL;
            ST_BOUND:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_err   <= {i_in.setpoint[DATA_W-1], i_in.setpoint}
                             - {i_in.measured[DATA_W-1], i_in.measured};
                    r_dt    <= i_in.time_step;
                    r_term  <= TERM_P;
                    r_chunk <= CHUNK_LO;
                    r_acc   <= '0;
                    r_sum   <= '0;
                    r_deriv <= '0;
                end
            end
            ST_ICLAMP: r_diff_neg <= diff[ERR_W];
            ST_DSIGN:  r_deriv <= deriv_val;
            ST_ACC: begin
                r_acc   <= r_acc + acc_add;
                r_chunk <= (r_chunk == CHUNK_HI) ? CHUNK_LO : r_chunk + 2'd1;
            end
            ST_SAT: begin
                r_sum  <= r_sum + {{(SUM_W-INT_W){term_val[INT_W-1]}}, term_val};
                r_acc  <= '0;
                r_term <= r_term + 2'd1;
            end
            ST_BOUND: begin
                if (r_dbound != '0) begin
                    if (r_sum > db_pos) begin
                        r_sum <= db_pos;
                    end else if (r_sum < db_neg) begin
                        r_sum <= db_neg;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) r_drive <= drive_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_last_err  <= '0;
            r_first     <= 1'b1;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_ibound    <= '0;
            r_dbound    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_P:         r_gain_p <= i_cfg_data;
                    CFG_GAIN_I:         r_gain_i <= i_cfg_data;
                    CFG_GAIN_D:         r_gain_d <= i_cfg_data;
                    CFG_INTEGRAL_BOUND: r_ibound <= i_cfg_data[BOUND_W-1:0];
                    CFG_DRIVE_BOUND:    r_dbound <= i_cfg_data[BOUND_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_IDLE && in_accept && i_in.command == CMD_CLEAR) begin
                r_integral <= '0;
                r_last_err <= '0;
                r_first    <= 1'b1;
            end

            if (r_state == ST_INC_ADD && r_dt != '0) begin
                r_integral <= isum_sat;
            end

            if (r_state == ST_ICLAMP && r_dt != '0 && r_ibound != '0) begin
                if (r_integral > ib_pos) begin
                    r_integral <= ib_pos;
                end else if (r_integral < ib_neg) begin
                    r_integral <= ib_neg;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_last_err  <= r_err;
                r_first     <= 1'b0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;
endmodule

`default_nettype wire

>>> hw/rtl/bpid_div.sv
`timescale 1ns / 1ps
`default_nettype none

module bpid_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bpid_pkg::NUM_W-1:0]    i_num,
    input  logic [bpid_pkg::DT_W-1:0]     i_den,
    output logic                          o_done,
    output logic [bpid_pkg::NUM_W-1:0]    o_quo
);
    import bpid_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DT_W:0]    rem_sh;
    logic [DT_W:0]    rem_sub;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = !rem_sub[DT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

`default_nettype wire

>>> hw/rtl/bpid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bpid_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_in_command,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [bpid_pkg::DATA_W-1:0]    i_out_drive
);
    import bpid_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_drive))
        else $error("stalled result changed or dropped");

    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_CLEAR && !i_out_valid
        |=> !i_out_valid)
        else $error("clear item gave a result");

    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_UPDATE |=> !i_in_ready)
        else $error("ready while an update is in progress");
endmodule

bind bounded_pid_controller bpid_checker u_bpid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_drive  (o_out.drive)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import bpid_pkg::*;

    typedef logic signed [127:0] t_wide;

    localparam t_wide INT_MAX = (t_wide'(1) <<< (INT_W - 1)) - 1;
    localparam t_wide INT_MIN = -(t_wide'(1) <<< (INT_W - 1));
    localparam t_wide DRV_MAX = (t_wide'(1) <<< (DATA_W - 1)) - 1;
    localparam t_wide DRV_MIN = -(t_wide'(1) <<< (DATA_W - 1));

    localparam int SETTLE_CYCLES = 100;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 100;

    class t_drive_scoreboard;
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic [BOUND_W-1:0]       integral_bound;
        logic [BOUND_W-1:0]       drive_bound;
        logic signed [INT_W-1:0]  integral_sum;
        logic signed [ERR_W-1:0]  last_error;
        logic                     first_step;
        logic signed [DATA_W-1:0] expected_drive[$];
        int                       errors;

        function new();
            gain_p         = '0;
            gain_i         = '0;
            gain_d         = '0;
            integral_bound = '0;
            drive_bound    = '0;
            integral_sum   = '0;
            last_error     = '0;
            first_step     = 1'b1;
            errors         = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_GAIN_P:         gain_p = data;
                CFG_GAIN_I:         gain_i = data;
                CFG_GAIN_D:         gain_d = data;
                CFG_INTEGRAL_BOUND: integral_bound = data[BOUND_W-1:0];
                CFG_DRIVE_BOUND:    drive_bound = data[BOUND_W-1:0];
                default: ;
            endcase
        endfunction

        function t_wide sat_int(t_wide x);
            if (x > INT_MAX) return INT_MAX;
            if (x < INT_MIN) return INT_MIN;
            return x;
        endfunction

        function t_wide clamp_to(t_wide x, logic [BOUND_W-1:0] bound);
            t_wide b;
            b = bound;
            if (b == 0) return x;
            if (x > b) return b;
            if (x < -b) return -b;
            return x;
        endfunction

        function t_wide gain_product(logic signed [DATA_W-1:0] gain, t_wide v);
            t_wide p;
            p = t_wide'(gain) * v;
            return sat_int(p >>> 16);
        endfunction

        function void note_input(logic cmd, logic signed [DATA_W-1:0] sp,
                                 logic signed [DATA_W-1:0] ms, logic [DT_W-1:0] dt);
            t_wide err;
            t_wide dtw;
            t_wide deriv;
            t_wide sum;
            t_wide drv;
            if (cmd == CMD_CLEAR) begin
                integral_sum = '0;
                last_error   = '0;
                first_step   = 1'b1;
                return;
            end
            err   = t_wide'(sp) - t_wide'(ms);
            dtw   = dt;
            deriv = 0;
            if (dt != 0) begin
                sum = sat_int(t_wide'(integral_sum) + ((err * dtw) >>> 16));
                sum = clamp_to(sum, integral_bound);
                integral_sum = sum[INT_W-1:0];
                if (!first_step)
                    deriv = sat_int(((err - t_wide'(last_error)) <<< 16) / dtw);
            end
            drv = gain_product(gain_p, err) + gain_product(gain_i, t_wide'(integral_sum))
                + gain_product(gain_d, deriv);
            drv = clamp_to(drv, drive_bound);
            if (drv > DRV_MAX) drv = DRV_MAX;
            if (drv < DRV_MIN) drv = DRV_MIN;
            expected_drive.push_back(drv[DATA_W-1:0]);
            last_error = err[ERR_W-1:0];
            first_step = 1'b0;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_drive(logic signed [DATA_W-1:0] got);
            logic signed [DATA_W-1:0] want;
            if (expected_drive.size() == 0) begin
                report($sformatf("drive %0d with none expected", got));
                return;
            end
            want = expected_drive.pop_front();
            if (got !== want)
                report($sformatf("drive %0d, expected %0d", got, want));
        endtask

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    bpid_in_if  in_ch();
    bpid_out_if out_ch();

    bounded_pid_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_drive_scoreboard sb;
    int  items_sent = 0;
    int  hold_seq = 0;
    int  hold_taken = 0;
    int  hold_left = 0;
    int  gap_left = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: checks results, idles in bursts, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready)
            sb.check_drive(out_ch.drive);
        if (hold_seq != hold_taken) begin
            hold_taken = hold_seq;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (gap_left > 0) begin
            out_ch.ready <= 1'b0;
            gap_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            gap_left = $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic cmd, logic signed [DATA_W-1:0] sp,
                             logic signed [DATA_W-1:0] ms, logic [DT_W-1:0] dt);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.setpoint  <= sp;
        in_ch.measured  <= ms;
        in_ch.time_step <= dt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(cmd, sp, ms, dt);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic configure(logic [DATA_W-1:0] gp, logic [DATA_W-1:0] gi,
                             logic [DATA_W-1:0] gd, logic [DATA_W-1:0] ib,
                             logic [DATA_W-1:0] db);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_INTEGRAL_BOUND, ib);
        write_reg(CFG_DRIVE_BOUND, db);
        // index past the last register, must be ignored
        write_reg(CFG_IDX_W'(CFG_DRIVE_BOUND + 1 + $urandom_range(0, 2)), $urandom);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom;
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return $urandom;
            default: return $urandom_range(1, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3, 4: return 16'($urandom);
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    // usually a clear, then a run of updates around one setpoint, with some noise mixed in
    task automatic run_session(int n_updates);
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] ms;
        logic [DT_W-1:0]          base_dt;
        if ($urandom_range(0, 3) != 0)
            send_item(CMD_CLEAR, $urandom, $urandom, 16'($urandom));
        sp      = pick_level();
        ms      = sp + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        base_dt = pick_dt();
        repeat (n_updates) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(1'($urandom), pick_level(), pick_level(), 16'($urandom));
            end else begin
                ms = ms + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
                send_item(CMD_UPDATE, sp, ms,
                          ($urandom_range(0, 7) == 0) ? pick_dt() : base_dt);
            end
        end
    endtask

    initial begin
        int  phase_start;
        bit  held;
        bit  paused;
        sb = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_UPDATE;
        in_ch.setpoint  = '0;
        in_ch.measured  = '0;
        in_ch.time_step = '0;
        out_ch.ready    = 1'b0;
        held            = 1'b0;
        paused          = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still at reset
        send_item(CMD_UPDATE, 32'h0005_0000, 32'h0001_0000, 16'd10);

        configure(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000, 32'h0, 32'h0);
        send_item(CMD_UPDATE, 32'h0003_0000, 32'h0001_0000, 16'd0);
        send_item(CMD_UPDATE, 32'h0003_0000, 32'h0002_0000, 16'h4000);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_item(CMD_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0, 16'h5A5A);
        send_item(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 16'd3);
        send_item(CMD_UPDATE, 32'h0000_0000, 32'h0000_0000, 16'd0);
        send_item(CMD_UPDATE, 32'h0000_0001, 32'h0000_0000, 16'd7);
        send_item(CMD_UPDATE, 32'h0000_0000, 32'h0000_0003, 16'd7);

        // extreme gains, integral bound data with the top bit set
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8001_0000, 32'h0002_0000);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h0002_8000, 32'h0000_0000, 16'h8000);
        send_item(CMD_CLEAR, 32'h0, 32'h0, 16'h0);
        send_item(CMD_UPDATE, -32'sh0000_0123, 32'h0000_0456, 16'd1);

        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(CMD_UPDATE, 32'h0000_0000, 32'h0000_0000, 16'd0);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        for (int p = 0; p < 6; p++) begin
            if (p == 5) calm <= 1'b1;
            configure(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_bound());
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == 2 && !held && items_sent - phase_start >= 30) begin
                    hold_seq <= hold_seq + 1;
                    held = 1'b1;
                end
                if (p == 3 && !paused && items_sent - phase_start >= 50) begin
                    drain();
                    paused = 1'b1;
                end
                run_session($urandom_range(3, 20));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d drive results never came", sb.pending()));
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> bounded_pid_controller.f
hw/rtl/bpid_pkg.sv
hw/rtl/bpid_in_if.sv
hw/rtl/bpid_out_if.sv
hw/rtl/bpid_div.sv
hw/rtl/bounded_pid_controller.sv
hw/rtl/bpid_checker.sv
test/tb.sv
